>>> hw/rtl/pisc_pkg.sv
package pisc_pkg;

	typedef enum logic [2:0] {
		CFG_CENTER_X       = 3'd0,
		CFG_CENTER_Y       = 3'd1,
		CFG_CENTER_Z       = 3'd2,
		CFG_SPHERE_RADIUS  = 3'd3,
		CFG_CAPSULE_BASE_Y = 3'd4,
		CFG_CAPSULE_RADIUS = 3'd5,
		CFG_CAPSULE_HEIGHT = 3'd6
	} cfg_index_t;

	localparam int unsigned CfgIndexBits = 3;
	localparam int unsigned OutBytes     = 1;

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

endpackage

>>> hw/rtl/pisc_diff.sv
module pisc_diff #(
	parameter int unsigned COORD_BITS = 16,
	parameter int unsigned MAG_BITS   = COORD_BITS + 2
) (
	input  logic                         clk,
	input  pisc_pkg::pipe_en_t           en,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] point_z,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic signed [COORD_BITS-1:0] center_z,
	input  logic signed [COORD_BITS-1:0] capsule_base_y,
	input  logic        [COORD_BITS-2:0] capsule_radius,
	input  logic        [COORD_BITS-2:0] capsule_height,
	output logic        [MAG_BITS-1:0]   mag_x_s2,
	output logic        [MAG_BITS-1:0]   mag_z_s2,
	output logic        [MAG_BITS-1:0]   mag_c_s2,
	output logic        [MAG_BITS-1:0]   mag_1_s2,
	output logic        [MAG_BITS-1:0]   mag_2_s2,
	output logic                         cyl_s2
);

	localparam int unsigned DW = COORD_BITS + 1;
	localparam int unsigned YW = COORD_BITS + 2;
	localparam int unsigned EW = COORD_BITS + 3;

	logic signed [DW-1:0] dx_s1, dz_s1, dc_s1;
	logic signed [YW-1:0] y1_s1, y2_s1;
	logic signed [COORD_BITS-1:0] py_s1;

	logic signed [EW-1:0] py_e, y1_e, y2_e, dy1, dy2;
	logic [EW-1:0] dy1_abs, dy2_abs;
	logic [DW-1:0] dx_abs, dz_abs, dc_abs;
	logic cyl_hit;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			dx_s1 <= DW'(point_x) - DW'(center_x);
			dz_s1 <= DW'(point_z) - DW'(center_z);
			dc_s1 <= DW'(point_y) - DW'(center_y);
			y1_s1 <= YW'(capsule_base_y) + $signed({3'b000, capsule_radius});
			y2_s1 <= YW'(capsule_base_y) + $signed({3'b000, capsule_height})
				- $signed({3'b000, capsule_radius});
			py_s1 <= point_y;
		end
	end

	always_comb begin
		py_e    = EW'(py_s1);
		y1_e    = EW'(y1_s1);
		y2_e    = EW'(y2_s1);
		dy1     = py_e - y1_e;
		dy2     = py_e - y2_e;
		dy1_abs = dy1[EW-1] ? EW'(-dy1) : EW'(dy1);
		dy2_abs = dy2[EW-1] ? EW'(-dy2) : EW'(dy2);
		dx_abs  = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
		dz_abs  = dz_s1[DW-1] ? DW'(-dz_s1) : DW'(dz_s1);
		dc_abs  = dc_s1[DW-1] ? DW'(-dc_s1) : DW'(dc_s1);
		cyl_hit = (py_e > y1_e && py_e < y2_e) || (py_e > y2_e && py_e < y1_e);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			mag_x_s2 <= MAG_BITS'(dx_abs);
			mag_z_s2 <= MAG_BITS'(dz_abs);
			mag_c_s2 <= MAG_BITS'(dc_abs);
			mag_1_s2 <= dy1_abs[MAG_BITS-1:0];
			mag_2_s2 <= dy2_abs[MAG_BITS-1:0];
			cyl_s2   <= cyl_hit;
		end
	end

endmodule

>>> hw/rtl/pisc_square.sv
module pisc_square #(
	parameter int unsigned COORD_BITS = 16,
	parameter int unsigned MAG_BITS   = COORD_BITS + 2
) (
	input  logic                            clk,
	input  pisc_pkg::pipe_en_t              en,
	input  logic [MAG_BITS-1:0]             mag_x_s2,
	input  logic [MAG_BITS-1:0]             mag_z_s2,
	input  logic [MAG_BITS-1:0]             mag_c_s2,
	input  logic [MAG_BITS-1:0]             mag_1_s2,
	input  logic [MAG_BITS-1:0]             mag_2_s2,
	input  logic                            cyl_s2,
	input  logic [COORD_BITS-2:0]           sphere_radius,
	input  logic [COORD_BITS-2:0]           capsule_radius,
	output logic [2*MAG_BITS-1:0]           sq_x_s3,
	output logic [2*MAG_BITS-1:0]           sq_z_s3,
	output logic [2*MAG_BITS-1:0]           sq_c_s3,
	output logic [2*MAG_BITS-1:0]           sq_1_s3,
	output logic [2*MAG_BITS-1:0]           sq_2_s3,
	output logic [2*COORD_BITS-3:0]         sr2_s3,
	output logic [2*COORD_BITS-3:0]         cr2_s3,
	output logic                            cyl_s3
);

	localparam int unsigned SW = 2 * MAG_BITS;
	localparam int unsigned RW = 2 * (COORD_BITS - 1);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sq_x_s3 <= SW'(mag_x_s2) * SW'(mag_x_s2);
			sq_z_s3 <= SW'(mag_z_s2) * SW'(mag_z_s2);
			sq_c_s3 <= SW'(mag_c_s2) * SW'(mag_c_s2);
			sq_1_s3 <= SW'(mag_1_s2) * SW'(mag_1_s2);
			sq_2_s3 <= SW'(mag_2_s2) * SW'(mag_2_s2);
			sr2_s3  <= RW'(sphere_radius) * RW'(sphere_radius);
			cr2_s3  <= RW'(capsule_radius) * RW'(capsule_radius);
			cyl_s3  <= cyl_s2;
		end
	end

endmodule

>>> hw/rtl/pisc_cmp.sv
module pisc_cmp #(
	parameter int unsigned COORD_BITS = 16,
	parameter int unsigned MAG_BITS   = COORD_BITS + 2
) (
	input  logic                    clk,
	input  pisc_pkg::pipe_en_t      en,
	input  logic [2*MAG_BITS-1:0]   sq_x_s3,
	input  logic [2*MAG_BITS-1:0]   sq_z_s3,
	input  logic [2*MAG_BITS-1:0]   sq_c_s3,
	input  logic [2*MAG_BITS-1:0]   sq_1_s3,
	input  logic [2*MAG_BITS-1:0]   sq_2_s3,
	input  logic [2*COORD_BITS-3:0] sr2_s3,
	input  logic [2*COORD_BITS-3:0] cr2_s3,
	input  logic                    cyl_s3,
	output logic                    inside_s5
);

	localparam int unsigned SW = 2 * MAG_BITS;
	localparam int unsigned AW = SW + 2;

	logic [SW:0]   horiz_s4;
	logic [SW-1:0] sq_c_s4, sq_1_s4, sq_2_s4;
	logic [AW-1:0] sr2_s4, cr2_s4;
	logic          cyl_s4;

	logic [AW-1:0] sum_c, sum_1, sum_2, horiz_e;
	logic          hit;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			horiz_s4 <= (SW+1)'(sq_x_s3) + (SW+1)'(sq_z_s3);
			sq_c_s4  <= sq_c_s3;
			sq_1_s4  <= sq_1_s3;
			sq_2_s4  <= sq_2_s3;
			sr2_s4   <= AW'(sr2_s3);
			cr2_s4   <= AW'(cr2_s3);
			cyl_s4   <= cyl_s3;
		end
	end

	always_comb begin
		horiz_e = AW'(horiz_s4);
		sum_c   = horiz_e + AW'(sq_c_s4);
		sum_1   = horiz_e + AW'(sq_1_s4);
		sum_2   = horiz_e + AW'(sq_2_s4);
		hit     = (sum_c < sr2_s4) || (sum_1 < cr2_s4) || (sum_2 < cr2_s4)
			|| (cyl_s4 && horiz_e < cr2_s4);
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			inside_s5 <= hit;
		end
	end

endmodule

>>> hw/rtl/point_in_sphere_or_capsule_top.sv
// Channel  Dir  Signals                                Contents
// s_axis   in   s_tvalid s_tready s_tdata              point_x, point_y, point_z
// m_axis   out  m_tvalid m_tready m_tdata              inside_res
// cfg      in   cfg_valid cfg_ready cfg_index cfg_data register index, value
//
// Five register stages: differences, magnitudes, squares, horizontal sum,
// final sum and strict compares. One point per cycle when the output is not stalled.
// Each stage loads when empty or when the stage after it moves, so bubbles
// close up and a stalled result does not block intake until the pipe is full.
// arst_n clears valid bits and all config registers; cfg_ready is always high.
module point_in_sphere_or_capsule_top #(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [W-1:0] point_x, [2W-1:W] point_y, [3W-1:2W] point_z, zero fill above
	input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] inside_res, zero fill above
	output logic [8*pisc_pkg::OutBytes-1:0]   m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pisc_pkg::CfgIndexBits-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]             cfg_data
);

	localparam int unsigned W  = COORD_BITS;
	localparam int unsigned MW = COORD_BITS + 2;

	logic signed [W-1:0] center_x_q, center_y_q, center_z_q, capsule_base_y_q;
	logic [W-2:0] sphere_radius_q, capsule_radius_q, capsule_height_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	pisc_pkg::pipe_en_t en;

	logic [MW-1:0] mag_x_s2, mag_z_s2, mag_c_s2, mag_1_s2, mag_2_s2;
	logic cyl_s2;
	logic [2*MW-1:0] sq_x_s3, sq_z_s3, sq_c_s3, sq_1_s3, sq_2_s3;
	logic [2*W-3:0] sr2_s3, cr2_s3;
	logic cyl_s3;
	logic inside_s5;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q       <= '0;
			center_y_q       <= '0;
			center_z_q       <= '0;
			sphere_radius_q  <= '0;
			capsule_base_y_q <= '0;
			capsule_radius_q <= '0;
			capsule_height_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (pisc_pkg::cfg_index_t'(cfg_index))
				pisc_pkg::CFG_CENTER_X:       center_x_q       <= cfg_data;
				pisc_pkg::CFG_CENTER_Y:       center_y_q       <= cfg_data;
				pisc_pkg::CFG_CENTER_Z:       center_z_q       <= cfg_data;
				pisc_pkg::CFG_SPHERE_RADIUS:  sphere_radius_q  <= cfg_data[W-2:0];
				pisc_pkg::CFG_CAPSULE_BASE_Y: capsule_base_y_q <= cfg_data;
				pisc_pkg::CFG_CAPSULE_RADIUS: capsule_radius_q <= cfg_data[W-2:0];
				pisc_pkg::CFG_CAPSULE_HEIGHT: capsule_height_q <= cfg_data[W-2:0];
				default: ;
			endcase
		end
	end

	assign rdy5 = !v_s5 || m_tready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign en.s1 = rdy1;
	assign en.s2 = rdy2;
	assign en.s3 = rdy3;
	assign en.s4 = rdy4;
	assign en.s5 = rdy5;

	assign s_tready = rdy1;
	assign m_tvalid = v_s5;
	assign m_tdata  = {{(8*pisc_pkg::OutBytes-1){1'b0}}, inside_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	pisc_diff #(
		.COORD_BITS(W),
		.MAG_BITS  (MW)
	) u_diff (
		.clk           (clk),
		.en            (en),
		.point_x       ($signed(s_tdata[W-1:0])),
		.point_y       ($signed(s_tdata[2*W-1:W])),
		.point_z       ($signed(s_tdata[3*W-1:2*W])),
		.center_x      (center_x_q),
		.center_y      (center_y_q),
		.center_z      (center_z_q),
		.capsule_base_y(capsule_base_y_q),
		.capsule_radius(capsule_radius_q),
		.capsule_height(capsule_height_q),
		.mag_x_s2      (mag_x_s2),
		.mag_z_s2      (mag_z_s2),
		.mag_c_s2      (mag_c_s2),
		.mag_1_s2      (mag_1_s2),
		.mag_2_s2      (mag_2_s2),
		.cyl_s2        (cyl_s2)
	);

	pisc_square #(
		.COORD_BITS(W),
		.MAG_BITS  (MW)
	) u_square (
		.clk           (clk),
		.en            (en),
		.mag_x_s2      (mag_x_s2),
		.mag_z_s2      (mag_z_s2),
		.mag_c_s2      (mag_c_s2),
		.mag_1_s2      (mag_1_s2),
		.mag_2_s2      (mag_2_s2),
		.cyl_s2        (cyl_s2),
		.sphere_radius (sphere_radius_q),
		.capsule_radius(capsule_radius_q),
		.sq_x_s3       (sq_x_s3),
		.sq_z_s3       (sq_z_s3),
		.sq_c_s3       (sq_c_s3),
		.sq_1_s3       (sq_1_s3),
		.sq_2_s3       (sq_2_s3),
		.sr2_s3        (sr2_s3),
		.cr2_s3        (cr2_s3),
		.cyl_s3        (cyl_s3)
	);

	pisc_cmp #(
		.COORD_BITS(W),
		.MAG_BITS  (MW)
	) u_cmp (
		.clk      (clk),
		.en       (en),
		.sq_x_s3  (sq_x_s3),
		.sq_z_s3  (sq_z_s3),
		.sq_c_s3  (sq_c_s3),
		.sq_1_s3  (sq_1_s3),
		.sq_2_s3  (sq_2_s3),
		.sr2_s3   (sr2_s3),
		.cr2_s3   (cr2_s3),
		.cyl_s3   (cyl_s3),
		.inside_s5(inside_s5)
	);

endmodule
